// File: design/analog_key_rapid_trigger_defines.svh
// assertion macros for the analog key rapid trigger block
`ifndef ANALOG_KEY_RAPID_TRIGGER_DEFINES_SVH
`define ANALOG_KEY_RAPID_TRIGGER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AKRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AKRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AKRT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AKRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/akrt_pkg.sv
// types and constants shared by the analog key rapid trigger modules
package akrt_pkg;

  localparam int KEY_W     = 4;
  localparam int DIST_W    = 10;
  localparam int TOL_W     = 8;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 10;

  localparam logic [MODE_W-1:0] MODE_DISABLED   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STATIC     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DYNAMIC    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CONTINUOUS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTUATION    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_SENS   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SENS = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STATIC_TOL   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TOL    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CONT_EXIT    = 4'd7;

  localparam logic [MODE_W-1:0] RST_MODE         = MODE_STATIC;
  localparam logic [DIST_W-1:0] RST_ACTUATION    = 10'd200;
  localparam logic [DIST_W-1:0] RST_RELEASE      = 10'd180;
  localparam logic [DIST_W-1:0] RST_PRESS_SENS   = 10'd40;
  localparam logic [DIST_W-1:0] RST_RELEASE_SENS = 10'd40;
  localparam logic [TOL_W-1:0]  RST_STATIC_TOL   = 8'd10;
  localparam logic [TOL_W-1:0]  RST_ENTRY_TOL    = 8'd10;
  localparam logic [DIST_W-1:0] RST_CONT_EXIT    = 10'd10;

  typedef struct packed {
    logic [KEY_W-1:0]  key_index;
    logic [DIST_W-1:0] distance;
    logic              calibrated;
  } in_t;

  typedef struct packed {
    logic key_pressed;
    logic toggled;
  } out_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DIST_W-1:0] act_level;
    logic [DIST_W-1:0] rel_level;
    logic [DIST_W-1:0] press_sensitivity;
    logic [DIST_W-1:0] release_sensitivity;
    logic [TOL_W-1:0]  static_tolerance;
    logic [TOL_W-1:0]  entry_tolerance;
    logic [DIST_W-1:0] continuous_exit_level;
  } cfg_t;

  typedef struct packed {
    logic              pressed;
    logic              zone;
    logic [DIST_W-1:0] peak;
  } key_state_t;

endpackage

// File: design/akrt_cfg_regs.sv
// configuration register file
module akrt_cfg_regs
  import akrt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_DAT_W-1:0] wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode                  <= RST_MODE;
      cfg_r.act_level             <= RST_ACTUATION;
      cfg_r.rel_level             <= RST_RELEASE;
      cfg_r.press_sensitivity     <= RST_PRESS_SENS;
      cfg_r.release_sensitivity   <= RST_RELEASE_SENS;
      cfg_r.static_tolerance      <= RST_STATIC_TOL;
      cfg_r.entry_tolerance       <= RST_ENTRY_TOL;
      cfg_r.continuous_exit_level <= RST_CONT_EXIT;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:         cfg_r.mode                  <= wr_data[MODE_W-1:0];
        REG_ACTUATION:    cfg_r.act_level             <= wr_data[DIST_W-1:0];
        REG_RELEASE:      cfg_r.rel_level             <= wr_data[DIST_W-1:0];
        REG_PRESS_SENS:   cfg_r.press_sensitivity     <= wr_data[DIST_W-1:0];
        REG_RELEASE_SENS: cfg_r.release_sensitivity   <= wr_data[DIST_W-1:0];
        REG_STATIC_TOL:   cfg_r.static_tolerance      <= wr_data[TOL_W-1:0];
        REG_ENTRY_TOL:    cfg_r.entry_tolerance       <= wr_data[TOL_W-1:0];
        REG_CONT_EXIT:    cfg_r.continuous_exit_level <= wr_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/akrt_key_store.sv
// per-key state memory with reset valid bits and write forwarding
module akrt_key_store
  import akrt_pkg::*;
#(
  parameter int NUM_KEYS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [KEY_W-1:0] rd_key,
  input  logic             wr_en,
  input  logic [KEY_W-1:0] wr_key,
  input  key_state_t       wr_state,
  output key_state_t       rd_state
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  key_state_t              mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]     key_vld_r;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        wr_addr;
  key_state_t              rd_raw_r;
  logic                    rd_vld_r;
  logic                    fwd_r;
  key_state_t              fwd_state_r;

  assign rd_addr = IDX_W'(rd_key);
  assign wr_addr = IDX_W'(wr_key);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw_r <= mem[rd_addr];
    end
  end

  // entries never written read as cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r <= '0;
    end else if (wr_en) begin
      key_vld_r[wr_addr] <= 1'b1;
    end
  end

  // a write landing on the same edge as the read wins over the stale entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= key_vld_r[rd_addr];
      fwd_r    <= wr_en && (wr_key == rd_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_state_r <= wr_state;
    end
  end

  assign rd_state = fwd_r    ? fwd_state_r :
                    rd_vld_r ? rd_raw_r    : '0;

endmodule

// File: design/akrt_update.sv
// one-sample state update for static and rapid trigger modes
module akrt_update
  import akrt_pkg::*;
#(
  parameter int MAX_TRAVEL = 400
) (
  input  cfg_t              cfg,
  input  key_state_t        cur,
  input  logic [DIST_W-1:0] distance,
  input  logic              calibrated,
  output key_state_t        nxt
);

  localparam logic [DIST_W:0] MAX_T = (DIST_W+1)'(MAX_TRAVEL);

  logic              cont;
  logic              leave;
  logic              z1;
  logic [DIST_W-1:0] pk1;
  logic [DIST_W:0]   entry_thr;
  logic              enter;
  logic              p2;
  logic              z2;
  logic [DIST_W-1:0] pk2;
  logic [DIST_W-1:0] rel_thr;
  logic [DIST_W:0]   press_sum;
  logic [DIST_W-1:0] press_thr;
  key_state_t        rapid;
  logic [DIST_W:0]   st_press_thr;
  logic [DIST_W-1:0] st_rel_thr;
  logic              st_pressed;
  logic [DIST_W-1:0] rel_pt_tol;

  assign cont = (cfg.mode == MODE_CONTINUOUS);

  // released key leaving the zone
  assign leave = cur.zone && !cur.pressed &&
                 (cont ? (distance <= cfg.continuous_exit_level)
                       : (distance < cfg.act_level));
  assign z1  = cur.zone && !leave;
  assign pk1 = leave ? '0 : cur.peak;

  assign entry_thr = {1'b0, cfg.act_level} + {3'b000, cfg.entry_tolerance};
  assign enter = !z1 && (cont || !cur.pressed) && ({1'b0, distance} >= entry_thr);
  assign p2  = enter ? 1'b1 : cur.pressed;
  assign z2  = enter ? 1'b1 : z1;
  assign pk2 = enter ? distance : pk1;

  assign rel_thr   = (pk2 < cfg.release_sensitivity) ? '0 : pk2 - cfg.release_sensitivity;
  assign press_sum = {1'b0, pk2} + {1'b0, cfg.press_sensitivity};
  assign press_thr = (press_sum > MAX_T) ? MAX_T[DIST_W-1:0] : press_sum[DIST_W-1:0];

  always_comb begin
    rapid.pressed = p2;
    rapid.zone    = z2;
    rapid.peak    = pk2;
    if (z2) begin
      if (p2) begin
        if (distance > pk2) begin
          rapid.peak = distance;
        end else if (distance <= rel_thr) begin
          rapid.pressed = 1'b0;
          rapid.peak    = distance;
        end
      end else begin
        if (distance < pk2) begin
          rapid.peak = distance;
        end else if (distance >= press_thr) begin
          rapid.pressed = 1'b1;
          rapid.peak    = distance;
        end
      end
    end
  end

  assign st_press_thr = {1'b0, cfg.act_level} + {3'b000, cfg.static_tolerance};
  assign rel_pt_tol   = {2'b00, cfg.static_tolerance};
  assign st_rel_thr   = (cfg.rel_level < rel_pt_tol) ? '0
                                                     : cfg.rel_level - rel_pt_tol;
  assign st_pressed   = cur.pressed ? !(distance <= st_rel_thr)
                                    : ({1'b0, distance} >= st_press_thr);

  always_comb begin
    nxt = cur;
    if (calibrated) begin
      unique case (cfg.mode)
        MODE_DISABLED:   nxt = cur;
        MODE_STATIC:     nxt.pressed = st_pressed;
        MODE_DYNAMIC:    nxt = rapid;
        MODE_CONTINUOUS: nxt = rapid;
        default:         nxt = cur;
      endcase
    end
  end

endmodule

// File: design/analog_key_rapid_trigger.sv
// analog key actuation with rapid trigger, one travel sample per request
//
// in channel: one sample request per key (key_index, distance, calibrated).
// out channel: one result per request (key_pressed, toggled), in order.
// cfg channel: register writes by index, always ready; write only while idle.
// path: an accepted request waits in the input register, then moves to the
//   result register that drives out_valid and out_data.
// throughput: one request per cycle unless stalled; key state memory is read
//   when a request is taken and written as it moves to the result register,
//   with forwarding so back-to-back requests on the same key see fresh state.
// reset: config registers take their defaults, out_valid drops, and all key
//   state reads as cleared at once through per-key valid bits.
// receiver stall: the result register holds, the input stage holds behind
//   it, and in_ready drops only when both are full.
// keys at or above NUM_KEYS give a result of zeros and change nothing.
`include "analog_key_rapid_trigger_defines.svh"
module analog_key_rapid_trigger
  import akrt_pkg::*;
#(
  parameter int NUM_KEYS   = 16,
  parameter int MAX_TRAVEL = 400
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       s1_valid_r;
  in_t        s1_in_r;
  logic       s1_adv;
  logic       s1_in_range;
  logic       in_take;
  key_state_t cur_state;
  key_state_t new_state;
  logic       out_valid_r;
  out_t       out_data_r;
  out_t       result;

  assign cfg_ready = 1'b1;

  akrt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  assign s1_in_range = (32'(s1_in_r.key_index) < 32'(NUM_KEYS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_in_r <= in_data;
    end
  end

  akrt_key_store #(
    .NUM_KEYS (NUM_KEYS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_take),
    .rd_key   (in_data.key_index),
    .wr_en    (s1_adv && s1_in_range),
    .wr_key   (s1_in_r.key_index),
    .wr_state (new_state),
    .rd_state (cur_state)
  );

  akrt_update #(
    .MAX_TRAVEL (MAX_TRAVEL)
  ) u_update (
    .cfg        (cfg),
    .cur        (cur_state),
    .distance   (s1_in_r.distance),
    .calibrated (s1_in_r.calibrated),
    .nxt        (new_state)
  );

  assign result.key_pressed = s1_in_range && new_state.pressed;
  assign result.toggled     = s1_in_range && (new_state.pressed != cur_state.pressed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `AKRT_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, s1_adv, out_valid_r)
  `AKRT_ASSERT_SAME(a_uncal_no_change, clk, rst_n,
                    s1_valid_r && !s1_in_r.calibrated, !result.toggled)
  `AKRT_ASSERT_SAME(a_disabled_no_change, clk, rst_n,
                    s1_valid_r && (cfg.mode == MODE_DISABLED), !result.toggled)
  `AKRT_ASSERT_SAME(a_out_range_zero, clk, rst_n,
                    s1_valid_r && !s1_in_range, !result.key_pressed && !result.toggled)

endmodule
